// ===== design/assert_macros.svh =====
// Assertion helpers for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/stblur_pkg.sv =====
package stblur_pkg;

   // Default sizing of the line store and the filter window.
   localparam int MAX_RADIUS_DEF = 8;
   localparam int MAX_WIDTH_DEF  = 1024;

   // Field widths of the registers and the frame position counters.
   localparam int RAD_BITS = 4;
   localparam int COL_BITS = 11;
   localparam int ROW_BITS = 13;
   localparam int LIN_BITS = COL_BITS + ROW_BITS;
   localparam int NUM_CH   = 4;
   localparam int PIX_BITS = 8 * NUM_CH;

   // Register map, one 32-bit word per register.
   typedef enum logic [1:0] {
      REG_RADIUS_X     = 2'd0,
      REG_RADIUS_Y     = 2'd1,
      REG_FRAME_WIDTH  = 2'd2,
      REG_FRAME_HEIGHT = 2'd3
   } reg_idx_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic accept;
      logic setup;
      logic base;
      logic col_start;
      logic vread;
      logic div_load;
      logic div_sel_h;
      logic div_step;
      logic hacc;
      logic load_out;
   } dp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic emit;
      logic vlast;
      logic xlast;
      logic div_last;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== design/separable_tent_blur_argb.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  action, chan0..chan3
// rsp       out        rsp_valid/rsp_stall  out_chan0..out_chan3, frame_done
// csr       in         APB psel/penable     radius_x, radius_y, frame_width, frame_height
//
// A pixel beat that yields no result leaves the sequencer idle. A beat that yields a result
// walks the clipped window, at most 2*rx+1 columns by 2*ry+1 rows, through the single
// line store read port (one tap per cycle) and the bit-serial divider, once per column
// and once more for the horizontal sum.
// Reset is synchronous; the line store itself is not cleared.
// Input is stalled while a result is computed and in the cycle after a register write;
// a stalled result waits in the output register while the next beat is taken.
`include "assert_macros.svh"

module separable_tent_blur_argb import stblur_pkg::*; #(
   parameter int MAX_RADIUS = MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic [7:0]  req_chan3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_chan0,
   output logic [7:0]  rsp_out_chan1,
   output logic [7:0]  rsp_out_chan2,
   output logic [7:0]  rsp_out_chan3,
   output logic        rsp_frame_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int RW = $clog2(MAX_RADIUS + 1);

   logic [RAD_BITS-1:0] radius_x_ff, radius_y_ff;
   logic [COL_BITS-1:0] frame_width_ff;
   logic [ROW_BITS-1:0] frame_height_ff;
   logic                settle_ff;
   logic [LIN_BITS-1:0] lag_ff, lag_in;

   logic                cfg_wr;
   reg_idx_type         cfg_idx;
   logic [RW-1:0]       rx_eff, ry_eff;
   logic [COL_BITS-1:0] w_eff;
   logic [ROW_BITS-1:0] h_eff;
   dp_cmd_type          dp_cmd;
   dp_sts_type          dp_sts;
   logic                ctl_stall;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_idx_type'(paddr[3:2]);

   // Configuration registers; any write abandons the frame in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_x_ff     <= RAD_BITS'(1);
         radius_y_ff     <= RAD_BITS'(1);
         frame_width_ff  <= COL_BITS'(1024);
         frame_height_ff <= ROW_BITS'(768);
         settle_ff       <= 1'b0;
      end else begin
         settle_ff <= cfg_wr;
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_RADIUS_X:     radius_x_ff     <= pwdata[RAD_BITS-1:0];
               REG_RADIUS_Y:     radius_y_ff     <= pwdata[RAD_BITS-1:0];
               REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[COL_BITS-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= pwdata[ROW_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Register read-back.
   always_comb begin
      unique case (cfg_idx)
         REG_RADIUS_X:     prdata = 32'(radius_x_ff);
         REG_RADIUS_Y:     prdata = 32'(radius_y_ff);
         REG_FRAME_WIDTH:  prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = 32'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // Saturated working values and the output lag in pixels.
   always_comb begin
      rx_eff = (radius_x_ff > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_x_ff);
      ry_eff = (radius_y_ff > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_y_ff);
      if (frame_width_ff == '0) begin
         w_eff = COL_BITS'(1);
      end else if (frame_width_ff > MAX_WIDTH) begin
         w_eff = COL_BITS'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      h_eff  = (frame_height_ff == '0) ? ROW_BITS'(1) : frame_height_ff;
      lag_in = LIN_BITS'(ry_eff) * LIN_BITS'(w_eff) + LIN_BITS'(rx_eff);
   end

   always_ff @(posedge clock) begin
      lag_ff <= lag_in;
   end

   assign req_stall = ctl_stall;

   stblur_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .hold     (settle_ff),
      .req_valid(req_valid),
      .req_stall(ctl_stall),
      .sts      (dp_sts),
      .cmd      (dp_cmd)
   );

   stblur_dp #(
      .MAX_RADIUS(MAX_RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .restart       (cfg_wr),
      .cmd           (dp_cmd),
      .sts           (dp_sts),
      .rx            (rx_eff),
      .ry            (ry_eff),
      .w             (w_eff),
      .h             (h_eff),
      .lag           (lag_ff),
      .req_action    (req_action),
      .req_chan0     (req_chan0),
      .req_chan1     (req_chan1),
      .req_chan2     (req_chan2),
      .req_chan3     (req_chan3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_chan0 (rsp_out_chan0),
      .rsp_out_chan1 (rsp_out_chan1),
      .rsp_out_chan2 (rsp_out_chan2),
      .rsp_out_chan3 (rsp_out_chan3),
      .rsp_frame_done(rsp_frame_done)
   );

   // A new result never overwrites a beat that is still waiting.
   `CHK_IMPLY(a_load_free, clock, reset, dp_cmd.load_out, !rsp_valid || !rsp_stall, "result loaded over waiting beat")
   // A beat that starts a result computation blocks the next input beat.
   `CHK_NEXT(a_emit_busy, clock, reset, req_valid && !req_stall && dp_sts.emit, req_stall, "input taken while busy")
   // A register write holds off input in the following cycle while the lag settles.
   `CHK_NEXT(a_cfg_settle, clock, reset, cfg_wr, req_stall, "input taken right after register write")

endmodule

// ===== design/stblur_ram.sv =====
module stblur_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/stblur_ctl.sv =====
module stblur_ctl import stblur_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       hold,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      IDLE, SETUP, BASE, COL_START, VREAD, VFLUSH, VDIV_LOAD, VDIV,
      HACC, HDIV_LOAD, HDIV, OUT_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Input beats are taken only while the sequencer is idle.
   assign req_stall = (state_ff != IDLE) || hold;

   // Sequence: window setup, then per column a vertical sum and divide,
   // then the horizontal divide and the result hand-off.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.accept = req_valid && !hold;
            if (cmd.accept && sts.emit) begin
               state_in = SETUP;
            end
         end
         SETUP: begin
            cmd.setup = 1'b1;
            state_in  = BASE;
         end
         BASE: begin
            cmd.base = 1'b1;
            state_in = COL_START;
         end
         COL_START: begin
            cmd.col_start = 1'b1;
            state_in      = VREAD;
         end
         VREAD: begin
            cmd.vread = 1'b1;
            if (sts.vlast) begin
               state_in = VFLUSH;
            end
         end
         VFLUSH: begin
            state_in = VDIV_LOAD;
         end
         VDIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = VDIV;
         end
         VDIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = HACC;
            end
         end
         HACC: begin
            cmd.hacc = 1'b1;
            state_in = sts.xlast ? HDIV_LOAD : COL_START;
         end
         HDIV_LOAD: begin
            cmd.div_load  = 1'b1;
            cmd.div_sel_h = 1'b1;
            state_in      = HDIV;
         end
         HDIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = OUT_WAIT;
            end
         end
         OUT_WAIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

endmodule

// ===== design/stblur_dp.sv =====
module stblur_dp import stblur_pkg::*; #(
   parameter int MAX_RADIUS = MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  dp_cmd_type                        cmd,
   output dp_sts_type                        sts,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]   rx,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]   ry,
   input  logic [COL_BITS-1:0]               w,
   input  logic [ROW_BITS-1:0]               h,
   input  logic [LIN_BITS-1:0]               lag,
   input  logic                              req_action,
   input  logic [7:0]                        req_chan0,
   input  logic [7:0]                        req_chan1,
   input  logic [7:0]                        req_chan2,
   input  logic [7:0]                        req_chan3,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_chan0,
   output logic [7:0]                        rsp_out_chan1,
   output logic [7:0]                        rsp_out_chan2,
   output logic [7:0]                        rsp_out_chan3,
   output logic                              rsp_frame_done
);

   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int WTW  = $clog2(MAX_RADIUS + 2);
   localparam int NSUM = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
   localparam int NW   = $clog2(NSUM + 1);
   localparam int SUMW = $clog2(NSUM * 255 + 1);
   localparam int RING = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int AW   = $clog2(RING);

   // Frame position counters.
   logic [COL_BITS-1:0] in_col_ff, out_col_ff;
   logic [ROW_BITS-1:0] in_row_ff, out_row_ff;
   logic [LIN_BITS-1:0] in_lin_ff, out_lin_ff;
   logic                in_done_ff;

   // Window bounds and walk pointers.
   logic [COL_BITS-1:0] x0_ff, x1_ff, xx_ff;
   logic [ROW_BITS-1:0] y0_ff, y1_ff, yy_ff;
   logic [LIN_BITS-1:0] col_base_ff, addr_ff;

   // Accumulators and divider lanes.
   logic [WTW-1:0]  rd_wt_ff;
   logic            rd_vld_ff;
   logic [SUMW-1:0] vsum_ff [NUM_CH];
   logic [SUMW-1:0] hsum_ff [NUM_CH];
   logic [NW-1:0]   vnum_ff, hnum_ff;
   logic [SUMW-1:0] rem_ff [NUM_CH];
   logic [7:0]      quo_ff [NUM_CH];
   logic [SUMW-1:0] dsh_ff;
   logic [2:0]      cnt_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic [7:0] out_ff [NUM_CH];
   logic       done_ff;

   logic                  in_last, out_last, pix_wr;
   logic [LIN_BITS:0]     due;
   logic [PIX_BITS-1:0]   rd_data;
   logic [COL_BITS:0]     x_hi;
   logic [ROW_BITS:0]     y_hi;
   logic [ROW_BITS-1:0]   vdist;
   logic [COL_BITS-1:0]   hdist;
   logic [WTW-1:0]        vwt, hwt;
   logic [LIN_BITS-1:0]   row_off;

   assign in_last  = (in_row_ff == h - 1'b1) && (in_col_ff == w - 1'b1);
   assign out_last = (out_row_ff == h - 1'b1) && (out_col_ff == w - 1'b1);
   assign pix_wr   = cmd.accept && !req_action && !in_done_ff;

   // A pixel beat produces a result once the input leads by the lag.
   assign due = {1'b0, out_lin_ff} + {1'b0, lag};
   always_comb begin
      sts.emit     = req_action ? in_done_ff
                                : (!in_done_ff && ({1'b0, in_lin_ff} >= due));
      sts.vlast    = (yy_ff == y1_ff);
      sts.xlast    = (xx_ff == x1_ff);
      sts.div_last = (cnt_ff == 3'd0);
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Line store ring, addressed by the linear pixel index.
   stblur_ram #(
      .WIDTH(PIX_BITS),
      .DEPTH(1 << AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (pix_wr),
      .wr_addr(in_lin_ff[AW-1:0]),
      .wr_data({req_chan3, req_chan2, req_chan1, req_chan0}),
      .rd_en  (cmd.vread),
      .rd_addr(addr_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // Window arithmetic and tap weights.
   always_comb begin
      x_hi    = {1'b0, out_col_ff} + (COL_BITS+1)'(rx);
      y_hi    = {1'b0, out_row_ff} + (ROW_BITS+1)'(ry);
      vdist   = (yy_ff >= out_row_ff) ? yy_ff - out_row_ff : out_row_ff - yy_ff;
      hdist   = (xx_ff >= out_col_ff) ? xx_ff - out_col_ff : out_col_ff - xx_ff;
      vwt     = WTW'(ry) - WTW'(vdist) + 1'b1;
      hwt     = WTW'(rx) - WTW'(hdist) + 1'b1;
      row_off = LIN_BITS'(RW'(out_row_ff - y0_ff)) * LIN_BITS'(w);
   end

   // Frame counters: input side advances on pixel beats, output side on results.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_lin_ff  <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_lin_ff <= '0;
      end else if (cmd.load_out && out_last) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_lin_ff  <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_lin_ff <= '0;
      end else begin
         if (pix_wr) begin
            if (in_last) begin
               in_done_ff <= 1'b1;
            end else begin
               in_lin_ff <= in_lin_ff + 1'b1;
               if (in_col_ff == w - 1'b1) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + 1'b1;
               end else begin
                  in_col_ff <= in_col_ff + 1'b1;
               end
            end
         end
         if (cmd.load_out) begin
            out_lin_ff <= out_lin_ff + 1'b1;
            if (out_col_ff == w - 1'b1) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   // Window bounds, clipped at the frame edges, and the walk over taps.
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x0_ff <= (out_col_ff >= COL_BITS'(rx)) ? out_col_ff - COL_BITS'(rx) : '0;
         x1_ff <= (x_hi > {1'b0, w - 1'b1}) ? w - 1'b1 : x_hi[COL_BITS-1:0];
         y0_ff <= (out_row_ff >= ROW_BITS'(ry)) ? out_row_ff - ROW_BITS'(ry) : '0;
         y1_ff <= (y_hi > {1'b0, h - 1'b1}) ? h - 1'b1 : y_hi[ROW_BITS-1:0];
      end
      if (cmd.base) begin
         col_base_ff <= out_lin_ff - row_off - LIN_BITS'(out_col_ff - x0_ff);
         xx_ff       <= x0_ff;
      end else if (cmd.hacc) begin
         col_base_ff <= col_base_ff + 1'b1;
         xx_ff       <= xx_ff + 1'b1;
      end
      if (cmd.col_start) begin
         addr_ff <= col_base_ff;
         yy_ff   <= y0_ff;
      end else if (cmd.vread) begin
         addr_ff <= addr_ff + LIN_BITS'(w);
         yy_ff   <= yy_ff + 1'b1;
      end
      if (cmd.vread) begin
         rd_wt_ff <= vwt;
      end
   end

   // Read data is valid in the cycle after the read is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.vread;
      end
   end

   // Vertical and horizontal weighted sums per channel.
   always_ff @(posedge clock) begin
      if (cmd.col_start) begin
         vnum_ff <= '0;
      end else if (rd_vld_ff) begin
         vnum_ff <= vnum_ff + NW'(rd_wt_ff);
      end
      if (cmd.base) begin
         hnum_ff <= '0;
      end else if (cmd.hacc) begin
         hnum_ff <= hnum_ff + NW'(hwt);
      end
      for (int c = 0; c < NUM_CH; c++) begin
         if (cmd.col_start) begin
            vsum_ff[c] <= '0;
         end else if (rd_vld_ff) begin
            vsum_ff[c] <= vsum_ff[c] + SUMW'(rd_wt_ff) * SUMW'(rd_data[8*c +: 8]);
         end
         if (cmd.base) begin
            hsum_ff[c] <= '0;
         end else if (cmd.hacc) begin
            hsum_ff[c] <= hsum_ff[c] + SUMW'(hwt) * SUMW'(quo_ff[c]);
         end
      end
   end

   // Restoring divider, four lanes, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dsh_ff <= SUMW'(cmd.div_sel_h ? hnum_ff : vnum_ff) << 7;
         cnt_ff <= 3'd7;
         for (int c = 0; c < NUM_CH; c++) begin
            rem_ff[c] <= cmd.div_sel_h ? hsum_ff[c] : vsum_ff[c];
            quo_ff[c] <= '0;
         end
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            if (rem_ff[c] >= dsh_ff) begin
               rem_ff[c] <= rem_ff[c] - dsh_ff;
               quo_ff[c] <= {quo_ff[c][6:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   // Result register: holds a beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         done_ff <= out_last;
         for (int c = 0; c < NUM_CH; c++) begin
            out_ff[c] <= quo_ff[c];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_chan0  = out_ff[0];
   assign rsp_out_chan1  = out_ff[1];
   assign rsp_out_chan2  = out_ff[2];
   assign rsp_out_chan3  = out_ff[3];
   assign rsp_frame_done = done_ff;

endmodule
